### rtl/aead_pkg.sv
// ----------------------------------------------------------------------------
// aead_pkg
// Shared widths, character codes, parser state codes and action codes for the
// escape sequence action decoder.
// ----------------------------------------------------------------------------
package aead_pkg;

  localparam int CHAR_BITS  = 21;
  localparam int CP_W       = 21;
  localparam int ACTION_W   = 4;
  localparam int MODE_W     = 3;
  localparam int MATCH_W    = 3;

  typedef logic [CHAR_BITS-1:0] char_t;
  typedef logic [CP_W-1:0]      code_point_t;
  typedef logic [ACTION_W-1:0]  action_t;
  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [MATCH_W-1:0]   match_t;

  // character codes
  localparam char_t CH_NUL    = char_t'(8'h00);
  localparam char_t CH_BEL    = char_t'(8'h07);
  localparam char_t CH_BS     = char_t'(8'h08);
  localparam char_t CH_LF     = char_t'(8'h0a);
  localparam char_t CH_CR     = char_t'(8'h0d);
  localparam char_t CH_ESC    = char_t'(8'h1b);
  localparam char_t CH_ONE    = char_t'(8'h31);
  localparam char_t CH_TWO    = char_t'(8'h32);
  localparam char_t CH_THREE  = char_t'(8'h33);
  localparam char_t CH_SEMI   = char_t'(8'h3b);
  localparam char_t CH_UP     = char_t'(8'h41);
  localparam char_t CH_DOWN   = char_t'(8'h42);
  localparam char_t CH_RIGHT  = char_t'(8'h43);
  localparam char_t CH_LEFT   = char_t'(8'h44);
  localparam char_t CH_HOME   = char_t'(8'h48);
  localparam char_t CH_ED     = char_t'(8'h4a);
  localparam char_t CH_EL     = char_t'(8'h4b);
  localparam char_t CH_CSI    = char_t'(8'h5b);
  localparam char_t CH_BSLASH = char_t'(8'h5c);
  localparam char_t CH_OSC    = char_t'(8'h5d);
  localparam char_t CH_RIS    = char_t'(8'h63);
  localparam char_t CH_HVP    = char_t'(8'h66);
  localparam char_t FINAL_LO  = char_t'(8'h40);
  localparam char_t FINAL_HI  = char_t'(8'h7e);

  // parser modes
  localparam mode_t MODE_NORMAL  = 3'd0;
  localparam mode_t MODE_ESCAPE  = 3'd1;
  localparam mode_t MODE_CSI     = 3'd2;
  localparam mode_t MODE_OSC     = 3'd3;
  localparam mode_t MODE_OSC_ESC = 3'd4;

  // csi parameter matcher
  localparam match_t PM_EMPTY = 3'd0;
  localparam match_t PM_TWO   = 3'd1;
  localparam match_t PM_THREE = 3'd2;
  localparam match_t PM_SEMI  = 3'd3;
  localparam match_t PM_ONE   = 3'd4;
  localparam match_t PM_ONE_S = 3'd5;
  localparam match_t PM_ONE_1 = 3'd6;
  localparam match_t PM_OTHER = 3'd7;

  // display actions
  localparam action_t ACT_PRINT = 4'd0;
  localparam action_t ACT_NL    = 4'd1;
  localparam action_t ACT_CR    = 4'd2;
  localparam action_t ACT_BS    = 4'd3;
  localparam action_t ACT_BELL  = 4'd4;
  localparam action_t ACT_CLEAR = 4'd5;
  localparam action_t ACT_EOL   = 4'd6;
  localparam action_t ACT_HOME  = 4'd7;
  localparam action_t ACT_UP    = 4'd8;
  localparam action_t ACT_DOWN  = 4'd9;
  localparam action_t ACT_RIGHT = 4'd10;
  localparam action_t ACT_LEFT  = 4'd11;

  typedef struct packed {
    logic    emit;
    action_t action;
    mode_t   mode_next;
    match_t  match_next;
  } step_t;

endpackage

### rtl/aead_step.sv
// ----------------------------------------------------------------------------
// aead_step
// One character step of the escape parser: next mode, next parameter match
// and the action, if any, for the current character.
// ----------------------------------------------------------------------------
module aead_step
  import aead_pkg::*;
(
  input  mode_t       mode,
  input  match_t      match,
  input  code_point_t code_point,
  output step_t       step,
  output code_point_t glyph
);

  char_t  c;
  logic   is_final;
  match_t match_adv;

  assign c        = code_point[CHAR_BITS-1:0];
  assign is_final = (c >= FINAL_LO) && (c <= FINAL_HI);
  assign glyph    = CP_W'(c);

  // parameter text matcher, only exact strings of interest are tracked
  always_comb begin
    unique case (match)
      PM_EMPTY: begin
        if (c == CH_TWO)        match_adv = PM_TWO;
        else if (c == CH_THREE) match_adv = PM_THREE;
        else if (c == CH_SEMI)  match_adv = PM_SEMI;
        else if (c == CH_ONE)   match_adv = PM_ONE;
        else                    match_adv = PM_OTHER;
      end
      PM_ONE:   match_adv = (c == CH_SEMI) ? PM_ONE_S : PM_OTHER;
      PM_ONE_S: match_adv = (c == CH_ONE) ? PM_ONE_1 : PM_OTHER;
      default:  match_adv = PM_OTHER;
    endcase
  end

  always_comb begin
    step.emit       = 1'b0;
    step.action     = ACT_PRINT;
    step.mode_next  = mode;
    step.match_next = match;
    unique case (mode)
      MODE_ESCAPE: begin
        if (c == CH_CSI) begin
          step.mode_next  = MODE_CSI;
          step.match_next = PM_EMPTY;
        end else if (c == CH_OSC) begin
          step.mode_next = MODE_OSC;
        end else begin
          step.mode_next = MODE_NORMAL;
          if (c == CH_RIS) begin
            step.emit   = 1'b1;
            step.action = ACT_CLEAR;
          end
        end
      end
      MODE_CSI: begin
        if (!is_final) begin
          step.match_next = match_adv;
        end else begin
          step.mode_next  = MODE_NORMAL;
          step.match_next = PM_EMPTY;
          if (c == CH_ED) begin
            step.emit   = (match == PM_EMPTY) || (match == PM_TWO) || (match == PM_THREE);
            step.action = ACT_CLEAR;
          end else if (c == CH_EL) begin
            step.emit   = 1'b1;
            step.action = ACT_EOL;
          end else if (c == CH_HOME || c == CH_HVP) begin
            step.emit   = (match == PM_EMPTY) || (match == PM_SEMI) || (match == PM_ONE_1);
            step.action = ACT_HOME;
          end else if (c == CH_UP) begin
            step.emit   = 1'b1;
            step.action = ACT_UP;
          end else if (c == CH_DOWN) begin
            step.emit   = 1'b1;
            step.action = ACT_DOWN;
          end else if (c == CH_RIGHT) begin
            step.emit   = 1'b1;
            step.action = ACT_RIGHT;
          end else if (c == CH_LEFT) begin
            step.emit   = 1'b1;
            step.action = ACT_LEFT;
          end
        end
      end
      MODE_OSC: begin
        if (c == CH_BEL)      step.mode_next = MODE_NORMAL;
        else if (c == CH_ESC) step.mode_next = MODE_OSC_ESC;
      end
      MODE_OSC_ESC: begin
        step.mode_next = (c == CH_BSLASH) ? MODE_NORMAL : MODE_OSC;
      end
      default: begin
        step.mode_next = MODE_NORMAL;
        if (c == CH_ESC) begin
          step.mode_next = MODE_ESCAPE;
        end else if (c == CH_CR) begin
          step.emit   = 1'b1;
          step.action = ACT_CR;
        end else if (c == CH_BS) begin
          step.emit   = 1'b1;
          step.action = ACT_BS;
        end else if (c == CH_BEL) begin
          step.emit   = 1'b1;
          step.action = ACT_BELL;
        end else if (c == CH_LF) begin
          step.emit   = 1'b1;
          step.action = ACT_NL;
        end else if (c != CH_NUL) begin
          step.emit   = 1'b1;
          step.action = ACT_PRINT;
        end
      end
    endcase
  end

endmodule

### rtl/ansi_escape_action_decoder.sv
// ----------------------------------------------------------------------------
// ansi_escape_action_decoder
// Terminal escape sequence parser turning a character stream into display
// actions.
// ----------------------------------------------------------------------------
// Takes one character per clock while out_stall is not holding the output,
// and gives at most one action per character. A character passes through an
// input register, is decoded against the parser mode and csi parameter match,
// and its action lands in the output register once that slot is free or
// being drained. While the output does not stall, the sustained rate is one
// character per clock. Characters that cause no action (escape prefixes,
// parameter text, osc strings, nul) are absorbed without a gap. A stall on the
// output holds the input register, which then raises in_stall.
module ansi_escape_action_decoder
  import aead_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  code_point_t code_point,
  output logic        out_valid,
  input  logic        out_stall,
  output action_t     action,
  output code_point_t glyph
);

  logic        in_full;
  logic        in_full_next;
  code_point_t cp_reg;
  mode_t       mode;
  match_t      match;
  logic        out_valid_next;
  logic        advance;
  logic        accept;
  step_t       step;
  code_point_t step_glyph;

  aead_step u_step (
    .mode       (mode),
    .match      (match),
    .code_point (cp_reg),
    .step       (step),
    .glyph      (step_glyph)
  );

  // decode moves forward whenever the output slot is free or being drained
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_full_next = in_full;
    if (accept)       in_full_next = 1'b1;
    else if (advance) in_full_next = 1'b0;
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (advance) out_valid_next = step.emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      mode      <= MODE_NORMAL;
      match     <= PM_EMPTY;
    end else begin
      in_full   <= in_full_next;
      out_valid <= out_valid_next;
      if (advance) begin
        mode  <= step.mode_next;
        match <= step.match_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cp_reg <= code_point;
    if (advance && step.emit) begin
      action <= step.action;
      glyph  <= (step.action == ACT_PRINT) ? step_glyph : '0;
    end
  end

  a_glyph_only_print: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_PRINT) |-> glyph == '0)
    else $error("glyph set on a non-print action");

  a_action_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> action <= ACT_LEFT)
    else $error("action code out of range");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    advance && step.emit |=> out_valid && (action == $past(step.action)))
    else $error("decoded action did not reach the output register");

  a_csi_entry: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_CSI) && ($past(mode) != MODE_CSI) |-> match == PM_EMPTY)
    else $error("csi entered with stale parameter match");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && out_valid && out_stall)
    else $error("input stalled without a blocked output");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Character stream check of the escape sequence action decoder. A bursty
// driver feeds directed and random escape sequences, a local parser tracks
// mode and csi parameter match to predict each display action, and the output
// side stalls in shifting patterns while results are compared in order.
// ----------------------------------------------------------------------------
module testbench;
  import aead_pkg::*;

  localparam int RANDOM_ITEMS  = 1100;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_EVERY   = 40;

  typedef struct {
    code_point_t cp;
    bit          drain;
  } char_item_t;

  typedef struct {
    action_t     action;
    code_point_t glyph;
  } action_rec_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  code_point_t code_point = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  action_t     action;
  code_point_t glyph;

  char_item_t   chars_to_send[$];
  action_rec_t  pending_actions[$];
  mode_t        pred_mode   = MODE_NORMAL;
  match_t       pred_match  = PM_EMPTY;
  bit           drain_next  = 1'b0;
  bit           in_fire     = 1'b0;
  int           burst_left  = 0;
  int           gap_left    = 0;
  int           idle_cycles = 0;
  int           err_count   = 0;
  stall_style_t stall_style = STALL_NONE;
  logic [7:0]   stall_phase = '0;

  ansi_escape_action_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .code_point (code_point),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .action     (action),
    .glyph      (glyph)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic match_t next_match(match_t m, char_t c);
    case (m)
      PM_EMPTY: begin
        if (c == CH_TWO) return PM_TWO;
        if (c == CH_THREE) return PM_THREE;
        if (c == CH_SEMI) return PM_SEMI;
        if (c == CH_ONE) return PM_ONE;
        return PM_OTHER;
      end
      PM_ONE:   return (c == CH_SEMI) ? PM_ONE_S : PM_OTHER;
      PM_ONE_S: return (c == CH_ONE) ? PM_ONE_1 : PM_OTHER;
      default:  return PM_OTHER;
    endcase
  endfunction

  function automatic void add_action(action_t act, code_point_t gl);
    action_rec_t rec;
    rec.action = act;
    rec.glyph  = gl;
    pending_actions.push_back(rec);
  endfunction

  function automatic void parse_char(code_point_t cp);
    char_t  c;
    match_t m;
    c = char_t'(cp);
    case (pred_mode)
      MODE_ESCAPE: begin
        if (c == CH_CSI) begin
          pred_match = PM_EMPTY;
          pred_mode  = MODE_CSI;
        end else if (c == CH_OSC) begin
          pred_mode = MODE_OSC;
        end else begin
          pred_mode = MODE_NORMAL;
          if (c == CH_RIS) add_action(ACT_CLEAR, '0);
        end
      end
      MODE_CSI: begin
        if (c < FINAL_LO || c > FINAL_HI) begin
          pred_match = next_match(pred_match, c);
        end else begin
          m          = pred_match;
          pred_mode  = MODE_NORMAL;
          pred_match = PM_EMPTY;
          // clear and home only fire for the parameter strings they accept
          if (c == CH_ED) begin
            if (m == PM_EMPTY || m == PM_TWO || m == PM_THREE) add_action(ACT_CLEAR, '0);
          end else if (c == CH_EL) begin
            add_action(ACT_EOL, '0);
          end else if (c == CH_HOME || c == CH_HVP) begin
            if (m == PM_EMPTY || m == PM_SEMI || m == PM_ONE_1) add_action(ACT_HOME, '0);
          end else if (c == CH_UP) begin
            add_action(ACT_UP, '0);
          end else if (c == CH_DOWN) begin
            add_action(ACT_DOWN, '0);
          end else if (c == CH_RIGHT) begin
            add_action(ACT_RIGHT, '0);
          end else if (c == CH_LEFT) begin
            add_action(ACT_LEFT, '0);
          end
        end
      end
      MODE_OSC: begin
        if (c == CH_BEL) pred_mode = MODE_NORMAL;
        else if (c == CH_ESC) pred_mode = MODE_OSC_ESC;
      end
      MODE_OSC_ESC: begin
        pred_mode = (c == CH_BSLASH) ? MODE_NORMAL : MODE_OSC;
      end
      default: begin
        pred_mode = MODE_NORMAL;
        if (c == CH_ESC) pred_mode = MODE_ESCAPE;
        else if (c == CH_CR) add_action(ACT_CR, '0);
        else if (c == CH_BS) add_action(ACT_BS, '0);
        else if (c == CH_BEL) add_action(ACT_BELL, '0);
        else if (c == CH_LF) add_action(ACT_NL, '0);
        else if (c != CH_NUL) add_action(ACT_PRINT, code_point_t'(c));
      end
    endcase
  endfunction

  function automatic void report_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
  endfunction

  function automatic void check_result(action_t act, code_point_t gl);
    action_rec_t want;
    if (pending_actions.size() == 0) begin
      report_error($sformatf("unexpected action %0d glyph 0x%0h", act, gl));
    end else begin
      want = pending_actions.pop_front();
      if (act !== want.action)
        report_error($sformatf("action expected %0d actual %0d", want.action, act));
      if (gl !== want.glyph)
        report_error($sformatf("glyph expected 0x%0h actual 0x%0h", want.glyph, gl));
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void queue_char(code_point_t cp);
    char_item_t item;
    item.cp    = cp;
    item.drain = drain_next;
    drain_next = 1'b0;
    chars_to_send.push_back(item);
  endfunction

  function automatic code_point_t random_char();
    case ($urandom_range(0, 5))
      0:       return code_point_t'($urandom);
      1:       return code_point_t'($urandom_range(0, 31));
      default: return code_point_t'($urandom_range(32, 126));
    endcase
  endfunction

  function automatic void queue_csi_params();
    int n;
    n = $urandom_range(1, 4);
    case ($urandom_range(0, 9))
      0: ;
      1: queue_char(CH_TWO);
      2: queue_char(CH_THREE);
      3: queue_char(CH_SEMI);
      4: begin
        queue_char(CH_ONE);
        queue_char(CH_SEMI);
        queue_char(CH_ONE);
      end
      5: queue_char(CH_ONE);
      6: begin
        queue_char(CH_ONE);
        queue_char(CH_SEMI);
      end
      7: begin
        // near miss on the home pattern
        queue_char(CH_ONE);
        queue_char(CH_SEMI);
        queue_char(CH_ONE);
        queue_char(code_point_t'($urandom_range(8'h30, 8'h39)));
      end
      8: repeat (n) queue_char(code_point_t'($urandom_range(8'h30, 8'h3f)));
      default: begin
        // anything outside the final byte range, esc and nul included
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) queue_char(code_point_t'($urandom_range(0, 8'h3f)));
          else queue_char(code_point_t'($urandom_range(8'h7f, 21'h1fffff)));
        end
      end
    endcase
  endfunction

  function automatic void queue_random_run();
    int          n;
    int          pick;
    code_point_t c;
    n    = $urandom_range(1, 6);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      repeat (n) queue_char(random_char());
    end else if (pick < 70) begin
      queue_char(CH_ESC);
      queue_char(CH_CSI);
      queue_csi_params();
      case ($urandom_range(0, 11))
        0:       queue_char(CH_ED);
        1:       queue_char(CH_EL);
        2:       queue_char(CH_HOME);
        3:       queue_char(CH_HVP);
        4:       queue_char(CH_UP);
        5:       queue_char(CH_DOWN);
        6:       queue_char(CH_RIGHT);
        7:       queue_char(CH_LEFT);
        default: queue_char(code_point_t'($urandom_range(FINAL_LO, FINAL_HI)));
      endcase
    end else if (pick < 80) begin
      c = ($urandom_range(0, 1) == 0) ? CH_RIS : random_char();
      if (c == CH_CSI || c == CH_OSC) c = CH_RIS;
      queue_char(CH_ESC);
      queue_char(c);
    end else if (pick < 90) begin
      queue_char(CH_ESC);
      queue_char(CH_OSC);
      repeat (n - 1) begin
        // esc inside the string that is not a terminator drops back to osc
        if ($urandom_range(0, 4) == 0) begin
          queue_char(CH_ESC);
          queue_char(code_point_t'($urandom_range(8'h20, 8'h5b)));
        end else begin
          queue_char(code_point_t'($urandom_range(8'h20, 8'h7e)));
        end
      end
      if ($urandom_range(0, 1) == 0) begin
        queue_char(CH_BEL);
      end else begin
        queue_char(CH_ESC);
        queue_char(CH_BSLASH);
      end
    end else begin
      repeat (n) queue_char(($urandom_range(0, 3) == 0) ? CH_ESC : code_point_t'($urandom));
    end
  endfunction

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (chars_to_send.size() == 0 ||
                   (chars_to_send[0].drain && pending_actions.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        code_point <= chars_to_send[0].cp;
        void'(chars_to_send.pop_front());
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8)
                                                    : $urandom_range(20, 80);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver back-pressure, style picked anew each time stall_phase wraps to zero
  always @(negedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    if (stall_phase == 8'd0) stall_style <= stall_style_t'($urandom_range(0, 3));
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_phase[2:0] < 3'd3);
    endcase
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      pred_mode   = MODE_NORMAL;
      pred_match  = PM_EMPTY;
      in_fire     <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) parse_char(code_point);
      if (out_valid && !out_stall) check_result(action, glyph);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int runs;
    runs = 0;

    // directed: plain, extremes, controls, clear, csi clear, home, osc
    queue_char(code_point_t'(8'h41));
    queue_char(code_point_t'(21'h1fffff));
    queue_char(CH_NUL);
    queue_char(CH_CR);
    queue_char(CH_BS);
    queue_char(CH_BEL);
    queue_char(CH_LF);
    queue_char(CH_ESC);
    queue_char(CH_RIS);
    queue_char(CH_ESC);
    queue_char(CH_CSI);
    queue_char(CH_TWO);
    queue_char(CH_ED);
    queue_char(CH_ESC);
    queue_char(CH_CSI);
    queue_char(CH_ONE);
    queue_char(CH_SEMI);
    queue_char(CH_ONE);
    queue_char(CH_HVP);
    queue_char(CH_ESC);
    queue_char(CH_OSC);
    queue_char(code_point_t'(8'h78));
    queue_char(CH_BEL);

    while (chars_to_send.size() < RANDOM_ITEMS) begin
      // now and then hold the sender until the output side has caught up
      if (runs % DRAIN_EVERY == 0) drain_next = 1'b1;
      queue_random_run();
      runs++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // checked on the rising edge, where the driver's queue and in_valid are steady
    while (!(chars_to_send.size() == 0 && !in_valid && pending_actions.size() == 0) &&
           idle_cycles < IDLE_LIMIT)
      @(posedge clk);

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("testbench: FAIL");
    end else begin
      repeat (SETTLE_CYCLES) @(negedge clk);
      if (err_count == 0 && pending_actions.size() == 0) begin
        $display("testbench: PASS");
      end else begin
        $display("testbench: FAIL");
      end
    end
    $finish;
  end

endmodule
